@@ hdl/tun_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, stage counts and shared types of the unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_W     = 16;
  localparam int NORM_FRAC   = 14;
  localparam int OUT_W       = NORM_FRAC + 2;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int MAG_W       = PROD_W;
  localparam int LIM_W       = 31;
  localparam int SQ_W        = 2 * LIM_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int Q_W         = 2 * NORM_FRAC + 3;
  localparam int ROOT_W      = NORM_FRAC + 2;
  localparam int OP_W        = 2 * ROOT_W;
  localparam int DIV_STAGES  = Q_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int COMP_STAGES = DIV_STAGES + SQRT_STAGES;
  localparam int PRE_STAGES  = 7;
  localparam int LAST        = PRE_STAGES + COMP_STAGES;
  localparam int NST         = LAST + 1;
  localparam int FL_LEN      = LAST - 3;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } flags_t;

endpackage

@@ hdl/tun_comp.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal component scaler
// Pipelined restoring divide of sq * 2^30 by s, then a pipelined integer
// square root of the quotient, one bit per stage.
// ----------------------------------------------------------------------------
module tun_comp (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tun_pkg::SQ_W-1:0]    sq,
  input  logic [tun_pkg::SUM_W-1:0]   s,
  output logic [tun_pkg::ROOT_W-1:0]  root
);

  logic [tun_pkg::SUM_W-1:0] rem  [tun_pkg::DIV_STAGES];
  logic [tun_pkg::SUM_W-1:0] sden [tun_pkg::DIV_STAGES];
  logic [tun_pkg::Q_W-1:0]   quo  [tun_pkg::DIV_STAGES];
  logic [tun_pkg::OP_W-1:0]  op   [tun_pkg::SQRT_STAGES];
  logic [tun_pkg::OP_W-1:0]  res  [tun_pkg::SQRT_STAGES];

  for (genvar k = 0; k < tun_pkg::DIV_STAGES; k++) begin : g_div
    logic [tun_pkg::SUM_W-1:0] prem;
    logic [tun_pkg::SUM_W-1:0] ps;
    logic [tun_pkg::Q_W-1:0]   pq;
    logic                      nbit;
    logic [tun_pkg::SUM_W:0]   cand;
    logic [tun_pkg::SUM_W+1:0] d;
    logic                      ge;

    if (k == 0) begin : g_first
      assign prem = {3'b000, sq[tun_pkg::SQ_W-1:1]};
      assign ps   = s;
      assign pq   = '0;
      assign nbit = sq[0];
    end else begin : g_rest
      assign prem = rem[k-1];
      assign ps   = sden[k-1];
      assign pq   = quo[k-1];
      assign nbit = 1'b0;
    end

    always_comb begin
      cand = {prem, nbit};
      d    = {1'b0, cand} - {2'b00, ps};
      ge   = !d[tun_pkg::SUM_W+1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? d[tun_pkg::SUM_W-1:0] : cand[tun_pkg::SUM_W-1:0];
        sden[k] <= ps;
        quo[k]  <= {pq[tun_pkg::Q_W-2:0], ge};
      end
    end
  end

  for (genvar j = 0; j < tun_pkg::SQRT_STAGES; j++) begin : g_sqrt
    localparam logic [tun_pkg::OP_W-1:0] ONE =
      tun_pkg::OP_W'(1) << (2 * (tun_pkg::SQRT_STAGES - 1 - j));
    logic [tun_pkg::OP_W-1:0] pop;
    logic [tun_pkg::OP_W-1:0] pres;
    logic [tun_pkg::OP_W-1:0] t;
    logic                     ge;

    if (j == 0) begin : g_first
      assign pop  = {{(tun_pkg::OP_W-tun_pkg::Q_W){1'b0}},
                     quo[tun_pkg::DIV_STAGES-1]};
      assign pres = '0;
    end else begin : g_rest
      assign pop  = op[j-1];
      assign pres = res[j-1];
    end

    always_comb begin
      t  = pres + ONE;
      ge = (pop >= t);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op[j]  <= ge ? pop - t : pop;
        res[j] <= ge ? (pres >> 1) + ONE : (pres >> 1);
      end
    end
  end

  assign root = res[tun_pkg::SQRT_STAGES-1][tun_pkg::ROOT_W-1:0];

endmodule

@@ hdl/triangle_unit_normal.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges, scaled to unit length in Q1.14.
// ----------------------------------------------------------------------------
// The slave channel takes one triangle per item: nine Q3.12 coordinates of
// vertices A, B and C. The master channel gives one item per triangle: the
// unit normal (B to A) x (B to C), each component rounded to nearest with
// ties away from zero, and a degenerate flag when the cross product is zero,
// in which case all components are zero.
// The path from the slave to the master channel is seven stages for
// differences, products, cross product, magnitude, range shift, squares and
// their sum, then 31 divider stages, 16 square root stages and the output
// register.
// Throughput is one item per cycle while nothing stalls: every stage takes a new item.
// When the receiver stalls, the output register holds its item. The stages
// behind it keep moving while the stage just before the output register is
// empty; once that stage holds an item, the input and the whole pipeline stall.
// Reset clears all valid bits; no item is in flight after reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up.
  input  logic [9*tun_pkg::COORD_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // nx, ny, nz from the lowest bit up.
  output logic [3*tun_pkg::OUT_W-1:0]    m_tdata,
  // degenerate.
  output logic                           m_tuser
);

  logic [tun_pkg::NST-1:0] v;
  logic                    adv_out;
  logic                    adv_pipe;

  logic signed [tun_pkg::DIFF_W-1:0]  dif [6];
  logic signed [tun_pkg::PROD_W-1:0]  prd [6];
  logic signed [tun_pkg::CROSS_W-1:0] crs [3];
  logic [tun_pkg::MAG_W-1:0]          mag [3];
  logic [tun_pkg::LIM_W-1:0]          lim [3];
  logic [tun_pkg::SQ_W-1:0]           sq5 [3];
  logic [tun_pkg::SQ_W-1:0]           sq6 [3];
  logic [tun_pkg::SUM_W-1:0]          ssum;
  logic [tun_pkg::ROOT_W-1:0]         root [3];
  tun_pkg::flags_t                    fl [tun_pkg::FL_LEN];
  logic [tun_pkg::OUT_W-1:0]          nout [3];
  logic                               degen;

  logic signed [tun_pkg::DIFF_W-1:0]  dif_next [6];
  logic [tun_pkg::MAG_W-1:0]          orv;
  logic [1:0]                         sh;

  assign adv_out  = !v[tun_pkg::LAST] || m_tready;
  assign adv_pipe = adv_out || !v[tun_pkg::LAST-1];
  assign s_tready = adv_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv_pipe) begin
        v[tun_pkg::LAST-1:0] <= {v[tun_pkg::LAST-2:0], s_tvalid};
      end
      if (adv_out) begin
        v[tun_pkg::LAST] <= v[tun_pkg::LAST-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif_next[i] = tun_pkg::DIFF_W'(
        $signed(s_tdata[i*tun_pkg::COORD_W +: tun_pkg::COORD_W]))
        - tun_pkg::DIFF_W'($signed(s_tdata[(i+3)*tun_pkg::COORD_W +: tun_pkg::COORD_W]));
      dif_next[i+3] = tun_pkg::DIFF_W'(
        $signed(s_tdata[(i+6)*tun_pkg::COORD_W +: tun_pkg::COORD_W]))
        - tun_pkg::DIFF_W'($signed(s_tdata[(i+3)*tun_pkg::COORD_W +: tun_pkg::COORD_W]));
    end
    orv = mag[0] | mag[1] | mag[2];
    priority if (orv[tun_pkg::MAG_W-1]) begin
      sh = 2'd3;
    end else if (orv[tun_pkg::MAG_W-2]) begin
      sh = 2'd2;
    end else if (orv[tun_pkg::MAG_W-3]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_pipe) begin
      dif <= dif_next;
      prd[0] <= dif[1] * dif[5];
      prd[1] <= dif[2] * dif[4];
      prd[2] <= dif[2] * dif[3];
      prd[3] <= dif[0] * dif[5];
      prd[4] <= dif[0] * dif[4];
      prd[5] <= dif[1] * dif[3];
      for (int i = 0; i < 3; i++) begin
        crs[i] <= tun_pkg::CROSS_W'(prd[2*i]) - tun_pkg::CROSS_W'(prd[2*i+1]);
        mag[i] <= crs[i][tun_pkg::CROSS_W-1] ? tun_pkg::MAG_W'(-crs[i])
                                             : tun_pkg::MAG_W'(crs[i]);
        lim[i] <= tun_pkg::LIM_W'(mag[i] >> sh);
        sq5[i] <= tun_pkg::SQ_W'(lim[i]) * tun_pkg::SQ_W'(lim[i]);
        sq6[i] <= sq5[i];
      end
      ssum <= tun_pkg::SUM_W'(sq5[0]) + tun_pkg::SUM_W'(sq5[1]) + tun_pkg::SUM_W'(sq5[2]);
      fl[0].neg   <= {crs[2][tun_pkg::CROSS_W-1], crs[1][tun_pkg::CROSS_W-1],
                      crs[0][tun_pkg::CROSS_W-1]};
      fl[0].degen <= (crs[0] == '0) && (crs[1] == '0) && (crs[2] == '0);
      for (int i = 1; i < tun_pkg::FL_LEN; i++) begin
        fl[i] <= fl[i-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic [tun_pkg::ROOT_W:0]    rp1;
    logic [tun_pkg::OUT_W-1:0]   r;

    tun_comp u_comp (
      .clk  (clk),
      .en   (adv_pipe),
      .sq   (sq6[c]),
      .s    (ssum),
      .root (root[c])
    );

    always_comb begin
      rp1 = {1'b0, root[c]} + 1'b1;
      r   = tun_pkg::OUT_W'(rp1 >> 1);
    end

    always_ff @(posedge clk) begin
      if (adv_out) begin
        if (fl[tun_pkg::FL_LEN-1].degen) begin
          nout[c] <= '0;
        end else begin
          nout[c] <= fl[tun_pkg::FL_LEN-1].neg[c] ? -r : r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      degen <= fl[tun_pkg::FL_LEN-1].degen;
    end
  end

  assign m_tvalid = v[tun_pkg::LAST];
  assign m_tdata  = {nout[2], nout[1], nout[0]};
  assign m_tuser  = degen;

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate item carries a nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(nout[0]) <= 16384) && ($signed(nout[0]) >= -16384)
              && ($signed(nout[1]) <= 16384) && ($signed(nout[1]) >= -16384)
              && ($signed(nout[2]) <= 16384) && ($signed(nout[2]) >= -16384))
    else $error("normal component beyond unit magnitude");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles into the block and checks every normal it returns. The
// expected normal is computed in full integer precision: a bit-serial search
// for the rounded quotient compares squares so that no square root is taken.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [9*tun_pkg::COORD_W-1:0] tri_t;
  typedef struct packed {
    logic                      degen;
    logic [tun_pkg::OUT_W-1:0] z;
    logic [tun_pkg::OUT_W-1:0] y;
    logic [tun_pkg::OUT_W-1:0] x;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  tri_t s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [3*tun_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;

  tri_t    tri_queue[$];
  normal_t normal_queue[$];
  logic    s_fire = 1'b0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_cycles = 0;
  int      mismatches = 0;
  int      cycles = 0;

  triangle_unit_normal DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rounded magnitude of one component: largest r <= 2^NORM_FRAC with
  // (2r-1)^2 * s <= mag^2 * 2^(2*NORM_FRAC+2), which gives ties away from zero.
  function automatic logic [tun_pkg::OUT_W-1:0] unit_mag(longint unsigned mag,
                                                         longint unsigned s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint unsigned r;
    longint unsigned t;
    longint unsigned odd;
    rhs = 128'(mag * mag) << (2 * tun_pkg::NORM_FRAC + 2);
    r = 0;
    for (int b = tun_pkg::NORM_FRAC; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t <= (64'd1 << tun_pkg::NORM_FRAC)) begin
        odd = 2 * t - 1;
        lhs = 128'(odd * odd) * 128'(s);
        if (lhs <= rhs) r = t;
      end
    end
    return tun_pkg::OUT_W'(r);
  endfunction

  function automatic normal_t face_normal(tri_t d);
    longint signed c[9];
    longint signed n[3];
    longint signed ix, iy, iz, jx, jy, jz;
    longint unsigned mag[3];
    longint unsigned big, s;
    logic [tun_pkg::OUT_W-1:0] r[3];
    normal_t res;
    for (int i = 0; i < 9; i++)
      c[i] = longint'($signed(d[i*tun_pkg::COORD_W +: tun_pkg::COORD_W]));
    ix = c[0] - c[3]; iy = c[1] - c[4]; iz = c[2] - c[5];
    jx = c[6] - c[3]; jy = c[7] - c[4]; jz = c[8] - c[5];
    n[0] = iy * jz - iz * jy;
    n[1] = iz * jx - ix * jz;
    n[2] = ix * jy - iy * jx;
    res = '0;
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      res.degen = 1'b1;
      return res;
    end
    big = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? -n[i] : n[i];
      if (mag[i] > big) big = mag[i];
    end
    while (big >= (64'd1 << tun_pkg::LIM_W)) begin
      big = big >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    for (int i = 0; i < 3; i++) begin
      r[i] = unit_mag(mag[i], s);
      if (n[i] < 0) r[i] = -r[i];
    end
    res.x = r[0]; res.y = r[1]; res.z = r[2];
    return res;
  endfunction

  function automatic tri_t pack_tri(int v[9]);
    tri_t d;
    for (int i = 0; i < 9; i++)
      d[i*tun_pkg::COORD_W +: tun_pkg::COORD_W] = tun_pkg::COORD_W'(v[i]);
    return d;
  endfunction

  function automatic tri_t random_tri();
    int v[9];
    int m;
    int k;
    k = $urandom_range(9);
    for (int i = 0; i < 9; i++) v[i] = $urandom;
    if (k >= 5 && k <= 7) begin
      for (int i = 3; i < 9; i++)
        v[i] = v[i % 3] + $urandom_range(16) - 8;
    end else if (k == 8) begin
      // Collinear vertices give a zero cross product.
      m = $urandom_range(3) - 1;
      for (int i = 0; i < 3; i++) begin
        v[i] = v[i + 3] + $urandom_range(64) - 32;
        v[i + 6] = v[i + 3] + m * (v[i] - v[i + 3]);
      end
    end else if (k == 9) begin
      // Extreme corners.
      for (int i = 0; i < 9; i++) v[i] = $urandom_range(1) ? 32767 : -32768;
    end
    return pack_tri(v);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Driver.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_fire)) begin
      if (tri_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_tdata <= tri_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && $urandom_range(99) >= recv_idle;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    s_fire <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) normal_queue.push_back(face_normal(s_tdata));
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (normal_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %h", got);
      end else begin
        want = normal_queue.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z
            || got.degen !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%0d y=%0d z=%0d degen=%b, got x=%0d y=%0d z=%0d degen=%b",
                     $signed(want.x), $signed(want.y), $signed(want.z), want.degen,
                     $signed(got.x), $signed(got.y), $signed(got.z), got.degen);
        end
      end
    end
  end

  task automatic drain();
    wait (tri_queue.size() == 0);
    while (s_tvalid) @(posedge clk);
    while (normal_queue.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int v[9];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                         tri_queue.push_back(pack_tri(v));
    v = '{5, 5, 5, 5, 5, 5, 9, 1, 2};                         tri_queue.push_back(pack_tri(v));
    v = '{1, 2, 3, 0, 0, 0, 2, 4, 6};                         tri_queue.push_back(pack_tri(v));
    v = '{4096, 0, 0, 0, 0, 0, 0, 4096, 0};                   tri_queue.push_back(pack_tri(v));
    v = '{0, 4096, 0, 0, 0, 0, 4096, 0, 0};                   tri_queue.push_back(pack_tri(v));
    v = '{0, 0, 4096, 0, 0, 0, 4096, 0, 0};                   tri_queue.push_back(pack_tri(v));
    v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                         tri_queue.push_back(pack_tri(v));
    v = '{1, 1, 0, 0, 0, 0, 0, 0, 1};                         tri_queue.push_back(pack_tri(v));
    v = '{1, 1, 1, 0, 0, 0, 1, -1, 0};                        tri_queue.push_back(pack_tri(v));
    v = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768};
    tri_queue.push_back(pack_tri(v));
    v = '{32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767};
    tri_queue.push_back(pack_tri(v));
    v = '{32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767};
    tri_queue.push_back(pack_tri(v));
    v = '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767};
    tri_queue.push_back(pack_tri(v));
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};                tri_queue.push_back(pack_tri(v));
    v = '{3, 4, 0, 0, 0, 0, 0, 0, 5};                         tri_queue.push_back(pack_tri(v));
    v = '{2, 1, 7, -3, 5, 1, 6, -2, 4};                       tri_queue.push_back(pack_tri(v));
    drain();

    send_idle = 23; recv_idle = 82;
    repeat (400) tri_queue.push_back(random_tri());
    drain();

    send_idle = 82; recv_idle = 23;
    repeat (400) tri_queue.push_back(random_tri());
    drain();

    send_idle = 0; recv_idle = 0;
    repeat (400) tri_queue.push_back(random_tri());
    hold_cycles = 300;
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tun_pkg.sv
hdl/tun_comp.sv
hdl/triangle_unit_normal.sv
sim/tb.sv
